### sv/frla_pkg.sv
// Shared types and constants for the frame rate limiter and averager.
package frla_pkg;

   localparam int TIME_W         = 32;
   localparam int FPS_W          = 22;
   localparam int DELAY_W        = 10;
   localparam int MAX_FPS_W      = 10;
   localparam int RATE_NUM       = 256000;
   localparam int BUDGET_MS      = 1000;
   localparam int WINDOW_DEFAULT = 10;

   localparam logic [MAX_FPS_W-1:0] MAX_FPS_RESET  = 10'd60;
   localparam logic [FPS_W-1:0]     FPS_DEFAULT_Q8 = 22'd15360;

   localparam logic ACTION_BEGIN = 1'b0;
   localparam logic ACTION_END   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_FPS_GO,
      ST_FPS_WAIT,
      ST_BUD_GO,
      ST_BUD_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic begin_tick;
      logic capture;
      logic update;
      logic mul;
      logic fps_start;
      logic fps_default;
      logic fps_take;
      logic bud_start;
      logic bud_take;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic sum_zero;
      logic div_idle;
      logic out_free;
   } sts_type;

endpackage

### sv/frla_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module frla_div #(
   parameter int NUM_W = 22,
   parameter int DEN_W = 36
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             idle,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   diff;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[NUM_W-1]};
      diff   = rem_sh - {1'b0, den_ff};
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (start) begin
         cnt_in = CNT_W'(NUM_W);
         quo_in = num;
         rem_in = '0;
         den_in = den;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign idle = (cnt_ff == '0);
   assign quo  = quo_ff;

endmodule

### sv/frla_dp.sv
// Datapath: tick registers, frame time ring, running sum, divider and result word.
module frla_dp #(
   parameter int WINDOW = frla_pkg::WINDOW_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  frla_pkg::cmd_type               cmd,
   output frla_pkg::sts_type               sts,
   input  logic [frla_pkg::TIME_W-1:0]     req_now_ms,
   input  logic                            csr_write_en,
   input  logic [frla_pkg::MAX_FPS_W-1:0]  csr_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [frla_pkg::FPS_W-1:0]      rsp_fps_q8,
   output logic [frla_pkg::TIME_W-1:0]     rsp_frame_time_ms,
   output logic [frla_pkg::DELAY_W-1:0]    rsp_delay_ms
);
   import frla_pkg::*;

   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W   = TIME_W + CNT_W;
   localparam int DIV_W   = (18 + CNT_W > FPS_W) ? 18 + CNT_W : FPS_W;

   logic [TIME_W-1:0]    ring_mem [WINDOW];
   logic [WINDOW-1:0]    vld_ff;
   logic [TIME_W-1:0]    rd_ff;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [TIME_W-1:0]    last_ff;
   logic                 seen_ff;
   logic [TIME_W-1:0]    start_ff;
   logic [TIME_W-1:0]    ft_ff, ft_in;
   logic [TIME_W-1:0]    elapsed_ff;
   logic [DIV_W-1:0]     prod_ff;
   logic [FPS_W-1:0]     fps_ff;
   logic [DELAY_W-1:0]   bud_ff;
   logic [MAX_FPS_W-1:0] max_fps_ff;
   logic [MAX_FPS_W-1:0] limit;
   logic [TIME_W-1:0]    old_val;
   logic [DELAY_W-1:0]   delay_in;
   logic                 rsp_valid_ff;
   logic [FPS_W-1:0]     rsp_fps_ff;
   logic [TIME_W-1:0]    rsp_ft_ff;
   logic [DELAY_W-1:0]   rsp_delay_ff;
   logic                 div_start;
   logic [DIV_W-1:0]     div_num;
   logic [SUM_W-1:0]     div_den;
   logic                 div_idle;
   logic [DIV_W-1:0]     div_quo;

   always_comb begin
      ft_in    = seen_ff ? (req_now_ms - last_ff) : '0;
      old_val  = vld_ff[slot_ff] ? rd_ff : '0;
      sum_in   = sum_ff - SUM_W'(old_val) + SUM_W'(ft_ff);
      slot_in  = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
      count_in = (count_ff < CNT_W'(WINDOW)) ? count_ff + 1'b1 : count_ff;
      limit    = (max_fps_ff == '0) ? MAX_FPS_W'(1) : max_fps_ff;
      delay_in = (TIME_W'(bud_ff) > elapsed_ff) ?
                 DELAY_W'(TIME_W'(bud_ff) - elapsed_ff) : '0;
      div_start = cmd.fps_start | cmd.bud_start;
      div_num   = cmd.fps_start ? prod_ff : DIV_W'(BUDGET_MS);
      div_den   = cmd.fps_start ? sum_ff : SUM_W'(limit);
   end

   frla_div #(
      .NUM_W (DIV_W),
      .DEN_W (SUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .idle  (div_idle),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      rd_ff <= ring_mem[slot_ff];
      if (cmd.update) begin
         ring_mem[slot_ff] <= ft_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         slot_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         start_ff     <= '0;
         max_fps_ff   <= MAX_FPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            max_fps_ff <= csr_write_data;
         end
         if (cmd.begin_tick) begin
            start_ff <= req_now_ms;
         end
         if (cmd.capture) begin
            last_ff <= req_now_ms;
            seen_ff <= 1'b1;
         end
         if (cmd.update) begin
            vld_ff[slot_ff] <= 1'b1;
            slot_ff         <= slot_in;
            count_ff        <= count_in;
            sum_ff          <= sum_in;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ft_ff      <= ft_in;
         elapsed_ff <= req_now_ms - start_ff;
      end
      if (cmd.mul) begin
         prod_ff <= DIV_W'(RATE_NUM) * DIV_W'(count_ff);
      end
      if (cmd.fps_default) begin
         fps_ff <= FPS_DEFAULT_Q8;
      end else if (cmd.fps_take) begin
         fps_ff <= div_quo[FPS_W-1:0];
      end
      if (cmd.bud_take) begin
         bud_ff <= div_quo[DELAY_W-1:0];
      end
      if (cmd.out_load) begin
         rsp_fps_ff   <= fps_ff;
         rsp_ft_ff    <= ft_ff;
         rsp_delay_ff <= delay_in;
      end
   end

   assign sts.sum_zero = (sum_ff == '0);
   assign sts.div_idle = div_idle;
   assign sts.out_free = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fps_q8        = rsp_fps_ff;
   assign rsp_frame_time_ms = rsp_ft_ff;
   assign rsp_delay_ms      = rsp_delay_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW))
      else $error("frame count beyond window");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff < SLOT_W'(WINDOW))
      else $error("ring slot beyond window");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded word not shown");
`endif

endmodule

### sv/frla_ctrl.sv
// Controller: sequences one frame event through ring update, rate division (skipped on a zero sum) and budget division.
module frla_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  frla_pkg::sts_type sts,
   output frla_pkg::cmd_type cmd
);
   import frla_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_action == ACTION_END)) begin
               state_in = ST_READ;
            end
         end
         ST_READ:     state_in = ST_MUL;
         ST_MUL:      state_in = ST_FPS_GO;
         ST_FPS_GO: begin
            state_in = sts.sum_zero ? ST_BUD_GO : ST_FPS_WAIT;
         end
         ST_FPS_WAIT: begin
            if (sts.div_idle) begin
               state_in = ST_BUD_GO;
            end
         end
         ST_BUD_GO:   state_in = ST_BUD_WAIT;
         ST_BUD_WAIT: begin
            if (sts.div_idle) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.begin_tick = req_valid && (req_action == ACTION_BEGIN);
            cmd.capture    = req_valid && (req_action == ACTION_END);
         end
         ST_READ:     cmd.update = 1'b1;
         ST_MUL:      cmd.mul = 1'b1;
         ST_FPS_GO: begin
            cmd.fps_default = sts.sum_zero;
            cmd.fps_start   = ~sts.sum_zero;
         end
         ST_FPS_WAIT: cmd.fps_take = sts.div_idle;
         ST_BUD_GO:   cmd.bud_start = 1'b1;
         ST_BUD_WAIT: cmd.bud_take = sts.div_idle;
         ST_FINISH:   cmd.out_load = sts.out_free;
         default:     cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_end_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_action == ACTION_END)) |=> (state_ff == ST_READ))
      else $error("frame end word not taken into the ring update");

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      (cmd.fps_start || cmd.bud_start) |=> !sts.div_idle)
      else $error("divider did not start");
`endif

endmodule

### sv/frame_rate_limiter_averager_unit.sv
// Frame begin word: records the begin tick, no result.
// Frame end word: result valid after ST_READ, ST_MUL, the rate division (skipped when the window
// sum is zero) and the budget division; both divisions use the shared one-bit-per-cycle divider.
// One word is worked on at a time: the next word is taken in the cycle after the result loads;
// the result register lets it enter while the previous result still waits for rsp_ready.
// Synchronous active-high reset clears the ring, sum, ticks and sets max_fps to 60.
module frame_rate_limiter_averager_unit #(
   parameter int WINDOW = frla_pkg::WINDOW_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_action,
   input  logic [frla_pkg::TIME_W-1:0]    req_now_ms,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [frla_pkg::FPS_W-1:0]     rsp_fps_q8,
   output logic [frla_pkg::TIME_W-1:0]    rsp_frame_time_ms,
   output logic [frla_pkg::DELAY_W-1:0]   rsp_delay_ms,
   input  logic                           csr_write_en,
   input  logic [frla_pkg::MAX_FPS_W-1:0] csr_write_data
);
   import frla_pkg::*;

   cmd_type cmd;
   sts_type sts;

   frla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .sts        (sts),
      .cmd        (cmd)
   );

   frla_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_now_ms        (req_now_ms),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_fps_q8        (rsp_fps_q8),
      .rsp_frame_time_ms (rsp_frame_time_ms),
      .rsp_delay_ms      (rsp_delay_ms)
   );

endmodule

### verif/tb_frame_rate_limiter_averager_unit.sv
// Self-checking testbench for frame_rate_limiter_averager_unit with a built-in rate predictor.
`timescale 1ns / 100ps

module tb_frame_rate_limiter_averager_unit;
   import frla_pkg::*;

   localparam int RING_DEPTH    = WINDOW_DEFAULT;
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASE_WORDS   = 230;

   typedef struct packed {
      logic              action;
      logic [TIME_W-1:0] now_ms;
   } frame_event_type;

   typedef struct packed {
      logic [FPS_W-1:0]   fps_q8;
      logic [TIME_W-1:0]  frame_time_ms;
      logic [DELAY_W-1:0] delay_ms;
   } rate_report_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_action = ACTION_BEGIN;
   logic [TIME_W-1:0]    req_now_ms = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [FPS_W-1:0]     rsp_fps_q8;
   logic [TIME_W-1:0]    rsp_frame_time_ms;
   logic [DELAY_W-1:0]   rsp_delay_ms;
   logic                 csr_write_en = 1'b0;
   logic [MAX_FPS_W-1:0] csr_write_data = MAX_FPS_RESET;

   // predictor state
   logic [TIME_W-1:0]    frame_times [RING_DEPTH];
   int unsigned          ring_slot = 0;
   int unsigned          frames_held = 0;
   logic [35:0]          frame_time_total = '0;
   logic [TIME_W-1:0]    last_end_ms = '0;
   logic                 end_seen = 1'b0;
   logic [TIME_W-1:0]    begin_ms = '0;
   logic [MAX_FPS_W-1:0] fps_limit = MAX_FPS_RESET;

   frame_event_type      frame_events [$];
   rate_report_type      rate_reports_due [$];
   int unsigned          words_owed = 0;
   int unsigned          mismatch_count = 0;
   int unsigned          cycle_count = 0;
   int unsigned          req_pause = 0;
   int unsigned          rsp_pause = 0;
   bit                   req_calm = 1'b0;
   bit                   rsp_calm = 1'b0;
   logic [TIME_W-1:0]    tick_ms = '0;
   int unsigned          fps_plan [8];

   frame_rate_limiter_averager_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_fps_q8        (rsp_fps_q8),
      .rsp_frame_time_ms (rsp_frame_time_ms),
      .rsp_delay_ms      (rsp_delay_ms),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      foreach (frame_times[i]) frame_times[i] = '0;
   end

   function automatic logic [TIME_W-1:0] frame_budget_ms();
      return BUDGET_MS / ((fps_limit == '0) ? 1 : int'(fps_limit));
   endfunction

   function automatic void predict_frame_event(input logic action,
                                               input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] budget;
      logic [63:0]       quotient;
      rate_report_type   rpt;
      if (action == ACTION_BEGIN) begin
         begin_ms = now;
         return;
      end
      span = end_seen ? now - last_end_ms : '0;
      last_end_ms = now;
      end_seen = 1'b1;
      frame_time_total = frame_time_total - frame_times[ring_slot] + span;
      frame_times[ring_slot] = span;
      ring_slot = (ring_slot + 1 >= RING_DEPTH) ? 0 : ring_slot + 1;
      if (frames_held < RING_DEPTH) frames_held++;
      if (frame_time_total == '0) begin
         rpt.fps_q8 = FPS_DEFAULT_Q8;
      end else begin
         quotient = (64'(RATE_NUM) * 64'(frames_held)) / 64'(frame_time_total);
         rpt.fps_q8 = quotient[FPS_W-1:0];
      end
      budget = frame_budget_ms();
      elapsed = now - begin_ms;
      rpt.frame_time_ms = span;
      rpt.delay_ms = (budget > elapsed) ? DELAY_W'(budget - elapsed) : '0;
      rate_reports_due.push_back(rpt);
   endfunction

   function automatic void log_mismatch(input string what, input rate_report_type want,
                                        input rate_report_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s: expected fps_q8=%0d frame_time_ms=%0d delay_ms=%0d, got %0d %0d %0d",
                  what, want.fps_q8, want.frame_time_ms, want.delay_ms,
                  got.fps_q8, got.frame_time_ms, got.delay_ms);
   endfunction

   // request driver
   always @(posedge clock) begin
      logic            launch;
      frame_event_type ev;
      if (reset) begin
         req_valid <= 1'b0;
         req_pause <= 0;
      end else begin
         launch = req_valid && !req_ready;
         if (req_valid && req_ready) begin
            predict_frame_event(req_action, req_now_ms);
            words_owed--;
         end
         if (!launch) begin
            if (req_pause != 0) begin
               req_pause <= req_pause - 1;
            end else if (frame_events.size() != 0) begin
               ev = frame_events.pop_front();
               req_action <= ev.action;
               req_now_ms <= ev.now_ms;
               if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
               req_pause <= req_calm ? 0 : $urandom_range(0, 16);
               launch = 1'b1;
            end
         end
         req_valid <= launch;
      end
   end

   // response monitor
   always @(posedge clock) begin
      rate_report_type seen;
      rate_report_type want;
      int unsigned     hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_pause <= 0;
      end else begin
         hold = (rsp_pause != 0) ? rsp_pause - 1 : 0;
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_fps_q8, rsp_frame_time_ms, rsp_delay_ms};
            if (rate_reports_due.size() == 0) begin
               log_mismatch("unexpected word", '0, seen);
            end else begin
               want = rate_reports_due.pop_front();
               if (seen.fps_q8 !== want.fps_q8 || seen.frame_time_ms !== want.frame_time_ms ||
                   seen.delay_ms !== want.delay_ms)
                  log_mismatch("wrong word", want, seen);
            end
            if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
            hold = rsp_calm ? 0 : $urandom_range(0, 16);
         end
         rsp_pause <= hold;
         rsp_ready <= (hold == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_frame_rate_limiter_averager_unit failed");
         $finish;
      end
   end

   task automatic queue_event(input logic action, input logic [TIME_W-1:0] now);
      frame_event_type ev;
      ev.action = action;
      ev.now_ms = now;
      words_owed++;
      frame_events.push_back(ev);
   endtask

   task automatic wait_quiet();
      while (words_owed != 0 || rate_reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_fps(input int unsigned value);
      wait_quiet();
      csr_write_en <= 1'b1;
      csr_write_data <= MAX_FPS_W'(value);
      @(posedge clock);
      csr_write_en <= 1'b0;
      fps_limit = MAX_FPS_W'(value);
   endtask

   task automatic queue_frames(input int unsigned quota);
      int unsigned pushed;
      int unsigned roll;
      int unsigned burst;
      logic [TIME_W-1:0] noise;
      pushed = 0;
      while (pushed < quota) begin
         roll = $urandom_range(0, 99);
         if (roll < 68) begin
            tick_ms += $urandom_range(0, 3);
            queue_event(ACTION_BEGIN, tick_ms);
            tick_ms += $urandom_range(0, frame_budget_ms() + 4);
            queue_event(ACTION_END, tick_ms);
            pushed += 2;
         end else if (roll < 76) begin
            // same-tick ends: zero frame times, which drain the window total to zero once they fill the window
            burst = $urandom_range(1, 12);
            repeat (burst) queue_event(ACTION_END, tick_ms);
            pushed += burst;
         end else if (roll < 84) begin
            // closely spaced ends: push the rate towards its top
            burst = $urandom_range(1, 12);
            repeat (burst) begin
               tick_ms += $urandom_range(0, 1);
               queue_event(ACTION_END, tick_ms);
            end
            pushed += burst;
         end else if (roll < 92) begin
            noise = $urandom;
            queue_event(logic'($urandom_range(0, 1)), noise);
            if ($urandom_range(0, 1) == 0) tick_ms = noise;
            pushed += 1;
         end else if (roll < 95) begin
            tick_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
         end else begin
            tick_ms += $urandom_range(0, 20);
            queue_event(logic'($urandom_range(0, 1)), tick_ms);
            pushed += 1;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // end before any begin, wrap of the tick, equal ticks, budget edges
      queue_event(ACTION_END,   32'd5);
      queue_event(ACTION_BEGIN, 32'd100);
      queue_event(ACTION_END,   32'd110);
      queue_event(ACTION_BEGIN, 32'hFFFF_FFF0);
      queue_event(ACTION_END,   32'd5);
      queue_event(ACTION_END,   32'd5);
      queue_event(ACTION_BEGIN, 32'hFFFF_FFFF);
      queue_event(ACTION_END,   32'hFFFF_FFFF);
      queue_event(ACTION_BEGIN, 32'd0);
      queue_event(ACTION_END,   32'd0);
      queue_event(ACTION_BEGIN, 32'd7);
      queue_event(ACTION_END,   32'd23);
      queue_event(ACTION_BEGIN, 32'd30);
      queue_event(ACTION_END,   32'd45);
      queue_event(ACTION_BEGIN, 32'hAAAA_AAAA);
      queue_event(ACTION_END,   32'h5555_5555);
      queue_event(ACTION_BEGIN, 32'h5555_5555);
      queue_event(ACTION_END,   32'hAAAA_AAAA);
      tick_ms = $urandom;

      fps_plan = '{1000, 1, 0, 1023, 60, 0, 16, 0};
      fps_plan[5] = $urandom_range(2, 999);
      fps_plan[7] = $urandom_range(2, 999);
      foreach (fps_plan[p]) begin
         write_max_fps(fps_plan[p]);
         queue_frames(PHASE_WORDS);
      end

      wait_quiet();
      if (mismatch_count == 0) begin
         $display("tb_frame_rate_limiter_averager_unit passed");
      end else begin
         $display("tb_frame_rate_limiter_averager_unit failed");
      end
      $finish;
   end

endmodule
